>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed: %m");
// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition: %m");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/pfa_pkg.sv
// types, codes and reset layout of the partition fit allocator
// no dependencies
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int ENTRIES   = 16;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  // reset layout: busy, free, busy
  localparam logic [SIZE_BITS-1:0] RST_START1 = SIZE_BITS'(40);
  localparam logic [SIZE_BITS-1:0] RST_START2 = SIZE_BITS'(90);
  localparam logic [SIZE_BITS-1:0] RST_LEN0   = SIZE_BITS'(40);
  localparam logic [SIZE_BITS-1:0] RST_LEN1   = SIZE_BITS'(50);
  localparam logic [SIZE_BITS-1:0] RST_LEN2   = SIZE_BITS'(20);
  localparam logic [CNT_W-1:0]     RST_COUNT  = CNT_W'(3);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_BADSIZE = 3'd2,
    ST_NOPART  = 3'd3,
    ST_ALREADY = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic [SIZE_BITS-1:0] start;
    logic [SIZE_BITS-1:0] len;
    logic                 busy;
  } entry_t;

  // table entry after reset
  function automatic entry_t reset_entry(input int k);
    entry_t e;
    e = '0;
    unique case (k)
      0:       begin e.len = RST_LEN0; e.busy = 1'b1; end
      1:       begin e.start = RST_START1; e.len = RST_LEN1; end
      2:       begin e.start = RST_START2; e.len = RST_LEN2; e.busy = 1'b1; end
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

>>> hw/rtl/partition_fit_allocator_unit.sv
// partition fit allocator: ordered partition table with first, best, worst fit
// depends on pfa_pkg and assert_macros.svh
// allocate: scan one entry a cycle, then decide and register the result
// free: check, merge next, merge previous; error: no merge; read or bad code: respond
// one item at a time; the next beat is taken once the sequencer is back in idle
// async active-low reset restores the three-entry layout and first fit policy
`timescale 1ns / 1ps
`include "assert_macros.svh"

module partition_fit_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,     // fit_policy
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // request_size[15:0], partition_index[19:16], zero
  input  logic [1:0]  s_axis_tuser,   // command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // status, result_index, result_address,
                                      // result_size, result_busy
);

  localparam int SB = pfa_pkg::SIZE_BITS;
  localparam int IW = pfa_pkg::IDX_W;
  localparam int CW = pfa_pkg::CNT_W;
  localparam int NE = pfa_pkg::ENTRIES;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_FCHK   = 7'b0001000,
    S_FNEXT  = 7'b0010000,
    S_FPREV  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  pfa_pkg::entry_t       tbl_q [NE];
  pfa_pkg::entry_t       tbl_d [NE];
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [1:0]            policy_q;
  logic [SB-1:0]         size_q, size_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         scan_q, scan_d;
  logic                  found_q, found_d;
  logic [IW-1:0]         pick_q, pick_d;
  logic [SB-1:0]         best_q, best_d;
  logic [SB-1:0]         pstart_q, pstart_d;
  logic [SB-1:0]         acc_q, acc_d;
  pfa_pkg::status_e      status_q, status_d;
  logic                  ovalid_q, ovalid_d;
  logic [39:0]           odata_q, odata_d;

  logic [IW-1:0]         rd_idx;
  pfa_pkg::entry_t       rd;
  logic                  in_beat;
  logic                  out_free;
  logic                  fits;
  logic                  better;
  logic [IW-1:0]         idx_nx;
  logic [IW-1:0]         idx_pv;
  logic [IW-1:0]         pick_nx;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  assign idx_nx  = idx_q + IW'(1);
  assign idx_pv  = idx_q - IW'(1);
  assign pick_nx = pick_q + IW'(1);

  // single table read port, address chosen by the sequencer
  always_comb begin
    unique case (state_q)
      S_SCAN:  rd_idx = scan_q[IW-1:0];
      S_FNEXT: rd_idx = idx_nx;
      S_FPREV: rd_idx = idx_pv;
      default: rd_idx = idx_q;
    endcase
  end
  assign rd = tbl_q[rd_idx];

  // fit test and policy compare for the scanned entry
  assign fits   = !rd.busy && (rd.len >= size_q);
  assign better = ((policy_q == pfa_pkg::POL_BEST)  && (rd.len < best_q)) ||
                  ((policy_q == pfa_pkg::POL_WORST) && (rd.len > best_q));

  // sequencer and table update
  always_comb begin
    state_d  = state_q;
    tbl_d    = tbl_q;
    cnt_d    = cnt_q;
    size_d   = size_q;
    idx_d    = idx_q;
    scan_d   = scan_q;
    found_d  = found_q;
    pick_d   = pick_q;
    best_d   = best_q;
    pstart_d = pstart_q;
    acc_d    = acc_q;
    status_d = status_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          size_d   = s_axis_tdata[SB-1:0];
          idx_d    = s_axis_tdata[19:16];
          scan_d   = '0;
          found_d  = 1'b0;
          status_d = pfa_pkg::ST_NOPART;
          state_d  = S_RESP;
          unique case (pfa_pkg::cmd_e'(s_axis_tuser))
            pfa_pkg::CMD_ALLOC: begin
              if (s_axis_tdata[SB-1:0] == '0) begin
                status_d = pfa_pkg::ST_BADSIZE;
              end else begin
                state_d = S_SCAN;
              end
            end
            pfa_pkg::CMD_FREE: state_d = S_FCHK;
            pfa_pkg::CMD_READ: begin
              if ({1'b0, s_axis_tdata[19:16]} < cnt_q) status_d = pfa_pkg::ST_OK;
            end
            default: status_d = pfa_pkg::ST_NOPART;
          endcase
        end
      end

      // one entry per cycle through the table
      S_SCAN: begin
        if (scan_q >= cnt_q) begin
          state_d = S_DECIDE;
        end else begin
          scan_d = scan_q + CW'(1);
          if (fits && !found_q) begin
            found_d  = 1'b1;
            pick_d   = scan_q[IW-1:0];
            best_d   = rd.len;
            pstart_d = rd.start;
            if (policy_q != pfa_pkg::POL_BEST && policy_q != pfa_pkg::POL_WORST) begin
              state_d = S_DECIDE;
            end
          end else if (fits && better) begin
            pick_d   = scan_q[IW-1:0];
            best_d   = rd.len;
            pstart_d = rd.start;
          end
        end
      end

      // take whole, or split and insert busy part first; else NOFIT or FULL
      S_DECIDE: begin
        state_d = S_RESP;
        idx_d   = pick_q;
        if (!found_q) begin
          status_d = pfa_pkg::ST_NOFIT;
        end else if (best_q == size_q) begin
          tbl_d[pick_q].busy = 1'b1;
          status_d = pfa_pkg::ST_OK;
        end else if (cnt_q >= CW'(NE)) begin
          status_d = pfa_pkg::ST_FULL;
        end else begin
          for (int k = 1; k < NE; k++) begin
            if (IW'(k) > pick_q) tbl_d[k] = tbl_q[k-1];
          end
          tbl_d[pick_q].len    = size_q;
          tbl_d[pick_q].busy   = 1'b1;
          tbl_d[pick_nx].start = pstart_q + size_q;
          tbl_d[pick_nx].len   = best_q - size_q;
          tbl_d[pick_nx].busy  = 1'b0;
          cnt_d    = cnt_q + CW'(1);
          status_d = pfa_pkg::ST_OK;
        end
      end

      S_FCHK: begin
        state_d = S_RESP;
        if ({1'b0, idx_q} >= cnt_q) begin
          status_d = pfa_pkg::ST_NOPART;
        end else if (!rd.busy) begin
          status_d = pfa_pkg::ST_ALREADY;
        end else begin
          tbl_d[idx_q].busy = 1'b0;
          acc_d   = rd.len;
          state_d = S_FNEXT;
        end
      end

      // merge with a free successor
      S_FNEXT: begin
        state_d = S_FPREV;
        if (({1'b0, idx_q} + CW'(1) < cnt_q) && !rd.busy) begin
          for (int k = 0; k < NE - 1; k++) begin
            if (IW'(k) > idx_q) tbl_d[k] = tbl_q[k+1];
          end
          tbl_d[NE-1]      = '0;
          tbl_d[idx_q].len = acc_q + rd.len;
          acc_d            = acc_q + rd.len;
          cnt_d            = cnt_q - CW'(1);
        end
      end

      // merge with a free predecessor
      S_FPREV: begin
        state_d  = S_RESP;
        status_d = pfa_pkg::ST_OK;
        if ((idx_q != '0) && !rd.busy) begin
          for (int k = 0; k < NE - 1; k++) begin
            if (IW'(k) >= idx_q) tbl_d[k] = tbl_q[k+1];
          end
          tbl_d[NE-1]       = '0;
          tbl_d[idx_pv].len = rd.len + acc_q;
          idx_d             = idx_pv;
          cnt_d             = cnt_q - CW'(1);
        end
      end

      // register the result beat from the updated table
      S_RESP: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (status_q == pfa_pkg::ST_OK) begin
            odata_d = {rd.busy, rd.len, rd.start, idx_q, status_q};
          end else begin
            odata_d = {37'd0, status_q};
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control and table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= pfa_pkg::RST_COUNT;
      policy_q <= 2'd0;
      ovalid_q <= 1'b0;
      found_q  <= 1'b0;
      scan_q   <= '0;
      status_q <= pfa_pkg::ST_OK;
      for (int k = 0; k < NE; k++) tbl_q[k] <= pfa_pkg::reset_entry(k);
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      found_q  <= found_d;
      scan_q   <= scan_d;
      status_q <= status_d;
      tbl_q    <= tbl_d;
      if (cfg_valid_i && cfg_ready_o) policy_q <= cfg_data_i;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    size_q   <= size_d;
    idx_q    <= idx_d;
    pick_q   <= pick_d;
    best_q   <= best_d;
    pstart_q <= pstart_d;
    acc_q    <= acc_d;
    odata_q  <= odata_d;
  end

  // checks
  `ASSERT_PROP(a_cnt_range, clk_i, rst_ni, (cnt_q != '0) && (cnt_q <= CW'(NE)))
  `ASSERT_PROP(a_beat_leaves_idle, clk_i, rst_ni, in_beat |=> (state_q != S_IDLE))
  `ASSERT_PROP(a_cnt_step, clk_i, rst_ni,
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) ||
    (cnt_q + CW'(1) == $past(cnt_q)))
  `ASSERT_PROP(a_err_zero, clk_i, rst_ni,
    (ovalid_q && (odata_q[2:0] != pfa_pkg::ST_OK)) |-> (odata_q[39:3] == '0))

endmodule
